@@ hdl/oaht_pkg.sv @@
// Shared types and constants for the open-addressing hash table.
`default_nettype none
package oaht_pkg;
  localparam int TABLE_SLOTS_DEF = 256;
  localparam int KEY_BYTES_DEF   = 8;
  localparam int VALUE_BYTES_DEF = 8;
  localparam int KEY_W   = 64;
  localparam int VAL_W   = 64;
  localparam int SIZE_W  = 9;
  localparam int PNUM_W  = 8;
  localparam int SUM_W   = 17;
  localparam int CNT_W   = 9;
  localparam int SLOT_W  = 8;
  localparam int QUEUE_DEPTH = 2;

  // Request function codes.
  typedef enum logic [1:0] {
    FN_INSERT = 2'd0,
    FN_SEARCH = 2'd1,
    FN_PROBE  = 2'd2,
    FN_STATS  = 2'd3
  } func_t;

  // Configuration register indexes.
  localparam logic [0:0] REG_TABLE_SIZE = 1'd0;
  localparam logic [0:0] REG_PROBE_MODE = 1'd1;

  // Back-end sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD,
    ST_ADDR,
    ST_READ,
    ST_CHECK,
    ST_DONE
  } state_t;

  // Classified request handed from the front end to the back end.
  typedef struct packed {
    func_t             func;
    logic [KEY_W-1:0]  key;
    logic [VAL_W-1:0]  value;
    logic [PNUM_W-1:0] pnum;
  } req_t;

  // One result item.
  typedef struct packed {
    logic              success;
    logic [SLOT_W-1:0] slot;
    logic [VAL_W-1:0]  found;
    logic [SUM_W-1:0]  total;
    logic [CNT_W-1:0]  count;
  } rsp_t;
endpackage
`default_nettype wire

@@ hdl/oaht_ram.sv @@
// Generic single-port RAM with registered read.
`default_nettype none
module oaht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write-first is not needed; reads return old contents.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

@@ hdl/oaht_front.sv @@
// Front end: accepts requests, masks key and value, and queues them.
`default_nettype none
module oaht_front #(
  parameter int KEY_BYTES   = oaht_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES = oaht_pkg::VALUE_BYTES_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire oaht_pkg::req_t in_req,
  output logic                q_valid,
  input  wire logic           q_ready,
  output oaht_pkg::req_t      q_req
);
  localparam int KB = KEY_BYTES * 8;
  localparam int VB = VALUE_BYTES * 8;
  localparam int D  = oaht_pkg::QUEUE_DEPTH;

  oaht_pkg::req_t    entry_r [D];
  logic              wp_r, wp_nxt, rp_r, rp_nxt;
  logic [1:0]        cnt_r, cnt_nxt;
  oaht_pkg::req_t    masked;
  logic              push, pop;

  // Mask key and value to their configured byte widths.
  always_comb begin
    masked = in_req;
    masked.key = in_req.key & ({oaht_pkg::KEY_W{1'b1}} >> (oaht_pkg::KEY_W - KB));
    masked.value = in_req.value & ({oaht_pkg::VAL_W{1'b1}} >> (oaht_pkg::VAL_W - VB));
  end

  assign in_ready = (cnt_r != 2'(D));
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_req    = entry_r[rp_r];

  // Queue pointers and fill level.
  always_comb begin
    wp_nxt  = push ? ~wp_r : wp_r;
    rp_nxt  = pop ? ~rp_r : rp_r;
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wp_r] <= masked;
    end
  end
endmodule
`default_nettype wire

@@ hdl/oaht_back.sv @@
// Back end: computes the home slot, walks the probe path and updates the table.
`default_nettype none
module oaht_back #(
  parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic [oaht_pkg::SIZE_W-1:0]   table_size,
  input  wire logic                          probe_mode,
  input  wire logic                          q_valid,
  output logic                               q_ready,
  input  wire oaht_pkg::req_t                q_req,
  output logic                               out_valid,
  input  wire logic                          out_ready,
  output oaht_pkg::rsp_t                     out_rsp
);
  localparam int AW = $clog2(TABLE_SLOTS);
  localparam int NW = AW + 1;
  localparam int KW = oaht_pkg::KEY_W;
  // The probe counter must reach both the last table probe and any probe number.
  localparam int IW = (NW > oaht_pkg::PNUM_W) ? NW : oaht_pkg::PNUM_W;

  oaht_pkg::state_t state_r, state_nxt;
  oaht_pkg::req_t   req_r;
  logic [NW-1:0]    n_r;
  logic [NW:0]      rem_r;
  logic [6:0]       bit_r;
  logic [AW-1:0]    addr_r, step_r;
  logic [IW-1:0]    i_r;
  logic [TABLE_SLOTS-1:0] occ_r;
  logic             occ_hit_r;
  logic [oaht_pkg::SUM_W-1:0] sum_r;
  logic [oaht_pkg::CNT_W-1:0] cnt_r;
  logic             wrk_success_r;
  logic [oaht_pkg::SLOT_W-1:0] wrk_slot_r;
  logic [oaht_pkg::VAL_W-1:0]  wrk_found_r;
  oaht_pkg::rsp_t   rsp_r;
  logic             ovalid_r, ovalid_nxt;

  logic [KW-1:0]    key_q;
  logic [oaht_pkg::VAL_W-1:0] val_q;
  logic             ram_we;
  logic [5:0]       bit_idx;
  logic [NW+1:0]    ntrial;
  logic [NW:0]      sum_a;
  logic [NW:0]      stp_a;
  logic [NW:0]      step_inc;
  logic [AW-1:0]    addr_nxt, step_nxt;
  logic             key_eq, last_probe, pnum_hit, load_rsp;
  logic [oaht_pkg::SUM_W:0] sum_add;

  // Slot key and value stores.
  oaht_ram #(.WIDTH(KW), .DEPTH(TABLE_SLOTS)) u_key (
    .clk(clk), .we(ram_we), .addr(addr_r), .wdata(req_r.key), .rdata(key_q));
  oaht_ram #(.WIDTH(oaht_pkg::VAL_W), .DEPTH(TABLE_SLOTS)) u_val (
    .clk(clk), .we(ram_we), .addr(addr_r), .wdata(req_r.value), .rdata(val_q));

  // Remainder step of the restoring division, one key bit a cycle, MSB first.
  assign bit_idx = 6'(bit_r - 7'd1);
  assign ntrial  = {rem_r, req_r.key[bit_idx]};

  // Next probe address: add 1 (linear) or (i+1) mod n (triangular) modulo n.
  always_comb begin
    stp_a = probe_mode ? (NW+1)'(step_r) : (NW+1)'(1);
    if (stp_a >= (NW+1)'(n_r)) stp_a = stp_a - (NW+1)'(n_r);
    sum_a = (NW+1)'(addr_r) + stp_a;
    if (sum_a >= (NW+1)'(n_r)) sum_a = sum_a - (NW+1)'(n_r);
    addr_nxt = sum_a[AW-1:0];
  end

  // The triangular step register holds (i+1) mod n and wraps at n.
  always_comb begin
    step_inc = (NW+1)'(step_r) + 1'b1;
    if (step_inc >= (NW+1)'(n_r)) step_nxt = '0;
    else step_nxt = step_inc[AW-1:0];
  end

  assign key_eq     = (key_q == req_r.key);
  assign last_probe = (i_r == IW'(n_r - 1'b1));
  assign pnum_hit   = (i_r == IW'(req_r.pnum));
  assign q_ready    = (state_r == oaht_pkg::ST_IDLE);
  assign out_valid  = ovalid_r;
  assign out_rsp    = rsp_r;
  assign ram_we     = (state_r == oaht_pkg::ST_CHECK) && (req_r.func == oaht_pkg::FN_INSERT)
                      && (!occ_hit_r || key_eq);
  assign sum_add    = (oaht_pkg::SUM_W+1)'(sum_r) + (oaht_pkg::SUM_W+1)'(i_r) + 1'b1;
  assign load_rsp   = (state_r == oaht_pkg::ST_DONE) && (!ovalid_r || out_ready);
  assign ovalid_nxt = load_rsp || (ovalid_r && !out_ready);

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      oaht_pkg::ST_IDLE:  if (q_valid) state_nxt = oaht_pkg::ST_MOD;
      oaht_pkg::ST_MOD: begin
        if (bit_r == 7'd0) begin
          state_nxt = (req_r.func == oaht_pkg::FN_STATS) ? oaht_pkg::ST_DONE
                                                         : oaht_pkg::ST_ADDR;
        end
      end
      oaht_pkg::ST_ADDR: begin
        if (req_r.func == oaht_pkg::FN_PROBE) begin
          if (pnum_hit) state_nxt = oaht_pkg::ST_DONE;
        end else begin
          state_nxt = oaht_pkg::ST_READ;
        end
      end
      oaht_pkg::ST_READ:  state_nxt = oaht_pkg::ST_CHECK;
      oaht_pkg::ST_CHECK: begin
        if (!occ_hit_r || key_eq || last_probe) state_nxt = oaht_pkg::ST_DONE;
        else state_nxt = oaht_pkg::ST_ADDR;
      end
      oaht_pkg::ST_DONE:  if (load_rsp) state_nxt = oaht_pkg::ST_IDLE;
      default:            state_nxt = oaht_pkg::ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= oaht_pkg::ST_IDLE;
      occ_r    <= '0;
      sum_r    <= '0;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      ovalid_r <= ovalid_nxt;
      if (ram_we && !occ_hit_r) begin
        occ_r[addr_r] <= 1'b1;
        cnt_r <= cnt_r + 1'b1;
        sum_r <= sum_add[oaht_pkg::SUM_W] ? '1 : sum_add[oaht_pkg::SUM_W-1:0];
      end
    end
  end

  // Output register: loaded only when the previous result has been taken.
  always_ff @(posedge clk) begin
    if (load_rsp) begin
      rsp_r.success <= wrk_success_r;
      rsp_r.slot    <= wrk_slot_r;
      rsp_r.found   <= wrk_found_r;
      rsp_r.total   <= sum_r;
      rsp_r.count   <= cnt_r;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      oaht_pkg::ST_IDLE: begin
        req_r <= q_req;
        rem_r <= '0;
        bit_r <= 7'd64;
        if (table_size == '0) n_r <= NW'(1);
        else if (32'(table_size) > TABLE_SLOTS) n_r <= NW'(TABLE_SLOTS);
        else n_r <= NW'(table_size);
        wrk_success_r <= 1'b0;
        wrk_slot_r    <= '0;
        wrk_found_r   <= '0;
      end
      oaht_pkg::ST_MOD: begin
        if (bit_r != 7'd0) begin
          if (ntrial >= (NW+2)'(n_r)) rem_r <= (NW+1)'(ntrial - (NW+2)'(n_r));
          else rem_r <= (NW+1)'(ntrial);
          bit_r <= bit_r - 1'b1;
        end else begin
          addr_r <= rem_r[AW-1:0];
          i_r    <= '0;
          step_r <= (n_r == NW'(1)) ? '0 : AW'(1);
          if (req_r.func == oaht_pkg::FN_STATS) wrk_success_r <= 1'b1;
        end
      end
      oaht_pkg::ST_ADDR: begin
        occ_hit_r <= occ_r[addr_r];
        if (req_r.func == oaht_pkg::FN_PROBE) begin
          if (pnum_hit) begin
            wrk_success_r <= 1'b1;
            wrk_slot_r    <= oaht_pkg::SLOT_W'(addr_r);
          end else begin
            addr_r <= addr_nxt;
            step_r <= step_nxt;
            i_r    <= i_r + 1'b1;
          end
        end
      end
      oaht_pkg::ST_CHECK: begin
        if (req_r.func == oaht_pkg::FN_INSERT) begin
          if (!occ_hit_r || key_eq) begin
            wrk_success_r <= 1'b1;
            wrk_slot_r    <= oaht_pkg::SLOT_W'(addr_r);
          end
        end else if (occ_hit_r && key_eq) begin
          wrk_success_r <= 1'b1;
          wrk_slot_r    <= oaht_pkg::SLOT_W'(addr_r);
          wrk_found_r   <= val_q;
        end
        if (occ_hit_r && !key_eq && !last_probe) begin
          addr_r <= addr_nxt;
          step_r <= step_nxt;
          i_r    <= i_r + 1'b1;
        end
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

@@ hdl/open_addressing_hash_table.sv @@
// Top level of the open-addressing hash table.
// A request waits in a two-entry front queue. The back end takes it in IDLE, does
// the bit-serial key modulo in MOD (one key bit a cycle), walks each probe through
// ADDR, READ and CHECK for insert and search (slot RAM read and compare), repeats
// ADDR up to probe_number for a probe query, skips probing for statistics, and in
// DONE loads the output register, which presents it the cycle after. Requests are
// processed one at a time; a stalled output holds the back end.
`default_nettype none
module open_addressing_hash_table #(
  parameter int TABLE_SLOTS = oaht_pkg::TABLE_SLOTS_DEF,
  parameter int KEY_BYTES   = oaht_pkg::KEY_BYTES_DEF,
  parameter int VALUE_BYTES = oaht_pkg::VALUE_BYTES_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic [0:0]   cfg_index,
  input  wire logic [8:0]   cfg_wdata,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  // key_word[63:0], value_word[127:64], probe_number[135:128]
  input  wire logic [135:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]   s_axis_tuser,
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // success[0], slot_index[8:1], found_value[72:9], total_probes[89:73],
  // element_count[98:90]
  output logic [103:0]      m_axis_tdata
);
  logic [8:0] size_r;
  logic       mode_r;
  oaht_pkg::req_t in_req, q_req;
  oaht_pkg::rsp_t rsp;
  logic q_valid, q_ready;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      size_r <= 9'd256;
      mode_r <= 1'b0;
    end else if (cfg_we) begin
      if (cfg_index == oaht_pkg::REG_TABLE_SIZE) size_r <= cfg_wdata;
      else mode_r <= cfg_wdata[0];
    end
  end

  assign in_req.func  = oaht_pkg::func_t'(s_axis_tuser);
  assign in_req.key   = s_axis_tdata[63:0];
  assign in_req.value = s_axis_tdata[127:64];
  assign in_req.pnum  = s_axis_tdata[135:128];

  oaht_front #(.KEY_BYTES(KEY_BYTES), .VALUE_BYTES(VALUE_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(s_axis_tvalid), .in_ready(s_axis_tready),
    .in_req(in_req), .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req));

  oaht_back #(.TABLE_SLOTS(TABLE_SLOTS)) u_back (
    .clk(clk), .rst_n(rst_n), .table_size(size_r), .probe_mode(mode_r),
    .q_valid(q_valid), .q_ready(q_ready), .q_req(q_req),
    .out_valid(m_axis_tvalid), .out_ready(m_axis_tready), .out_rsp(rsp));

  assign m_axis_tdata = {5'd0, rsp.count, rsp.total, rsp.found, rsp.slot, rsp.success};
endmodule
`default_nettype wire
